// ===== rtl/ptne_pkg.sv =====
// Shared constants and types of the point table with nearest-point edit.
`default_nettype none
package ptne_pkg;

  localparam int COORD_W  = 16;
  localparam int POINT_W  = 2 * COORD_W;
  localparam int DIST_W   = 33;
  localparam int FUNC_W   = 3;
  localparam int STAT_W   = 2;
  localparam int POS_W    = 8;
  localparam int MIDX_W   = 8;
  localparam int PCNT_W   = 9;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 64;

  localparam logic [FUNC_W-1:0] FN_APPEND   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_FIND     = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DEL_NEAR = 3'd2;
  localparam logic [FUNC_W-1:0] FN_UPD_NEAR = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL_AT   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_UPD_AT   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  localparam logic REG_RADIUS = 1'b0;

  typedef struct packed {
    logic                       found;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
  } near_best_t;

endpackage
`default_nettype wire

// ===== rtl/ptne_if.sv =====
// Item channel interfaces for the operation input and the result output.
`default_nettype none
interface ptne_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [ptne_pkg::FUNC_W-1:0]          func;
  logic signed [ptne_pkg::COORD_W-1:0]  query_x;
  logic signed [ptne_pkg::COORD_W-1:0]  query_y;
  logic signed [ptne_pkg::COORD_W-1:0]  new_x;
  logic signed [ptne_pkg::COORD_W-1:0]  new_y;
  logic [ptne_pkg::POS_W-1:0]           position;

  modport source (output valid, func, query_x, query_y, new_x, new_y, position,
                  input ready);
  modport sink   (input valid, func, query_x, query_y, new_x, new_y, position,
                  output ready);
endinterface

interface ptne_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 found;
  logic [ptne_pkg::MIDX_W-1:0]          match_index;
  logic signed [ptne_pkg::COORD_W-1:0]  match_x;
  logic signed [ptne_pkg::COORD_W-1:0]  match_y;
  logic [ptne_pkg::STAT_W-1:0]          status;
  logic [ptne_pkg::PCNT_W-1:0]          point_count;

  modport source (output valid, found, match_index, match_x, match_y, status,
                  point_count, input ready);
  modport sink   (input valid, found, match_index, match_x, match_y, status,
                  point_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/ptne_cfg.sv =====
// APB register file holding the squared match radius.
`default_nettype none
module ptne_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ptne_pkg::CFG_AW-1:0]    paddr,
  input  logic [ptne_pkg::CFG_DW-1:0]    pwdata,
  output logic [ptne_pkg::CFG_DW-1:0]    prdata,
  output logic                           pready,
  output logic [ptne_pkg::DIST_W-1:0]    radius_r
);

  logic sel_radius;
  logic wr_en;

  assign pready     = 1'b1;
  assign sel_radius = (paddr[ptne_pkg::CFG_AW-1] == ptne_pkg::REG_RADIUS);
  assign wr_en      = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
    end else if (wr_en && sel_radius) begin
      radius_r <= pwdata[ptne_pkg::DIST_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_radius) begin
      prdata = ptne_pkg::CFG_DW'(radius_r);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ptne_mem.sv =====
// Point storage: one write port, one read port with registered read data.
`default_nettype none
module ptne_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data_r
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/ptne_near.sv =====
// Distance pipeline and running nearest-match tracker for the table scan.
`default_nettype none
module ptne_near #(
  parameter int AW = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 in_v,
  input  logic [AW-1:0]                        in_idx,
  input  logic [ptne_pkg::POINT_W-1:0]         in_xy,
  input  logic signed [ptne_pkg::COORD_W-1:0]  qx,
  input  logic signed [ptne_pkg::COORD_W-1:0]  qy,
  input  logic [ptne_pkg::DIST_W-1:0]          radius,
  output logic                                 busy,
  output logic [AW-1:0]                        best_idx,
  output ptne_pkg::near_best_t                 best
);

  localparam int CW  = ptne_pkg::COORD_W;
  localparam int DFW = CW + 1;
  localparam int SQW = 2 * CW;

  logic                         v1_r, v2_r, v3_r;
  logic [AW-1:0]                idx1_r, idx2_r, idx3_r;
  logic [ptne_pkg::POINT_W-1:0] xy1_r, xy2_r, xy3_r;
  logic signed [DFW-1:0]        dx_r, dy_r;
  logic signed [2*DFW-1:0]      prod_x, prod_y;
  logic [SQW-1:0]               sqx_r, sqy_r;
  logic [ptne_pkg::DIST_W-1:0]  dist_r;
  logic                         have_r, have_nxt;
  logic [ptne_pkg::DIST_W-1:0]  best_d_r;
  logic [AW-1:0]                best_idx_r;
  logic [ptne_pkg::POINT_W-1:0] best_xy_r;
  logic                         hit;

  assign prod_x   = dx_r * dx_r;
  assign prod_y   = dy_r * dy_r;
  assign hit      = v3_r && (dist_r <= radius) && (!have_r || (dist_r < best_d_r));
  assign have_nxt = start ? 1'b0 : (have_r | hit);
  assign busy     = v1_r | v2_r | v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      have_r <= 1'b0;
    end else begin
      v1_r   <= in_v;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      have_r <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= in_idx;
    xy1_r  <= in_xy;
    dx_r   <= DFW'(signed'(in_xy[ptne_pkg::POINT_W-1:CW])) - DFW'(qx);
    dy_r   <= DFW'(signed'(in_xy[CW-1:0])) - DFW'(qy);
    idx2_r <= idx1_r;
    xy2_r  <= xy1_r;
    sqx_r  <= prod_x[SQW-1:0];
    sqy_r  <= prod_y[SQW-1:0];
    idx3_r <= idx2_r;
    xy3_r  <= xy2_r;
    dist_r <= {1'b0, sqx_r} + {1'b0, sqy_r};
    if (hit) begin
      best_d_r   <= dist_r;
      best_idx_r <= idx3_r;
      best_xy_r  <= xy3_r;
    end
  end

  assign best_idx   = best_idx_r;
  assign best.found = have_r;
  assign best.x     = best_xy_r[ptne_pkg::POINT_W-1:CW];
  assign best.y     = best_xy_r[CW-1:0];

endmodule
`default_nettype wire

// ===== rtl/point_table_nearest_edit.sv =====
// Top level: ordered 2D point table with radius-bounded nearest search and edits.
//
//   channel   dir  handshake              payload
//   in_ch     in   valid/ready            func, query_x/y, new_x/y, position
//   out_ch    out  valid/ready            found, match_index, match_x/y, status, point_count
//   cfg_*     in   APB setup + access     radius_squared at byte address 0
//
// One item at a time. Append and other codes go straight to the result stage; an
// index update first reads the entry (S_IREAD, S_IDATA). Nearest ops issue one
// memory read per stored point, then the distance pipeline drains. Deletes then
// shift the later entries down one place through the point memory's write port.
// Reset clears count, radius, state and valid flags; the point memory needs no sweep.
// A result waiting on out_ch stalls only the following item's result stage.
`default_nettype none
module point_table_nearest_edit #(
  parameter int MAX_POINTS = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ptne_in_if.sink                        in_ch,
  ptne_out_if.source                     out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [ptne_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [ptne_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [ptne_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready
);

  localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = (CW > ptne_pkg::POS_W) ? CW : ptne_pkg::POS_W;
  localparam int XW = ptne_pkg::COORD_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_IREAD = 3'd3;
  localparam logic [2:0] S_IDATA = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                      state_r, state_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [CW-1:0]                   scan_r, scan_nxt;
  logic [CW-1:0]                   sh_r, sh_nxt;
  logic                            shv_r, sh_issue;
  logic [AW-1:0]                   shw_r;
  logic                            iss_v_r, scan_issue;
  logic [AW-1:0]                   iss_idx_r;
  logic [AW-1:0]                   act_r, act_nxt;
  logic [ptne_pkg::FUNC_W-1:0]     func_r;
  logic signed [XW-1:0]            qx_r, qy_r, nx_r, ny_r;
  logic                            res_found_r, res_found_nxt;
  logic [ptne_pkg::MIDX_W-1:0]     res_idx_r, res_idx_nxt;
  logic signed [XW-1:0]            res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic [ptne_pkg::STAT_W-1:0]     res_st_r, res_st_nxt;
  logic                            out_valid_r, out_valid_nxt, out_load;
  logic                            out_found_r;
  logic [ptne_pkg::MIDX_W-1:0]     out_idx_r;
  logic signed [XW-1:0]            out_x_r, out_y_r;
  logic [ptne_pkg::STAT_W-1:0]     out_st_r;
  logic [ptne_pkg::PCNT_W-1:0]     out_cnt_r;

  logic                            accept;
  logic                            near_start, near_busy;
  logic [AW-1:0]                   best_idx;
  ptne_pkg::near_best_t            best;
  logic [ptne_pkg::DIST_W-1:0]     radius;
  logic                            wr_en;
  logic [AW-1:0]                   wr_addr, rd_addr;
  logic [ptne_pkg::POINT_W-1:0]    wr_data, rd_data;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  ptne_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .radius_r (radius)
  );

  ptne_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW),
    .DW    (ptne_pkg::POINT_W)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  ptne_near #(
    .AW (AW)
  ) u_near (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (near_start),
    .in_v     (iss_v_r),
    .in_idx   (iss_idx_r),
    .in_xy    (rd_data),
    .qx       (qx_r),
    .qy       (qy_r),
    .radius   (radius),
    .busy     (near_busy),
    .best_idx (best_idx),
    .best     (best)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    sh_nxt        = sh_r;
    act_nxt       = act_r;
    sh_issue      = 1'b0;
    scan_issue    = 1'b0;
    near_start    = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = act_r;
    wr_data       = {nx_r, ny_r};
    rd_addr       = act_r;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    res_st_nxt    = res_st_r;
    out_load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_found_nxt = 1'b0;
          res_idx_nxt   = '0;
          res_x_nxt     = '0;
          res_y_nxt     = '0;
          res_st_nxt    = ptne_pkg::ST_OK;
          state_nxt     = S_DONE;
          unique case (in_ch.func) inside
            ptne_pkg::FN_APPEND: begin
              if (count_r >= MAX_CNT) begin
                res_st_nxt = ptne_pkg::ST_FULL;
              end else begin
                wr_en       = 1'b1;
                wr_addr     = count_r[AW-1:0];
                wr_data     = {in_ch.new_x, in_ch.new_y};
                res_idx_nxt = ptne_pkg::MIDX_W'(count_r);
                count_nxt   = count_r + CW'(1);
              end
            end
            ptne_pkg::FN_FIND, ptne_pkg::FN_DEL_NEAR, ptne_pkg::FN_UPD_NEAR: begin
              scan_nxt   = '0;
              near_start = 1'b1;
              state_nxt  = S_SCAN;
            end
            ptne_pkg::FN_DEL_AT, ptne_pkg::FN_UPD_AT: begin
              if (PW'(in_ch.position) < PW'(count_r)) begin
                act_nxt   = AW'(in_ch.position);
                state_nxt = S_IREAD;
              end else begin
                res_st_nxt  = ptne_pkg::ST_RANGE;
                res_idx_nxt = in_ch.position;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_r < count_r) begin
          rd_addr    = scan_r[AW-1:0];
          scan_issue = 1'b1;
          scan_nxt   = scan_r + CW'(1);
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!iss_v_r && !near_busy) begin
          state_nxt = S_DONE;
          if (best.found) begin
            act_nxt       = best_idx;
            res_found_nxt = 1'b1;
            res_idx_nxt   = ptne_pkg::MIDX_W'(best_idx);
            res_x_nxt     = best.x;
            res_y_nxt     = best.y;
            if (func_r == ptne_pkg::FN_UPD_NEAR) begin
              wr_en   = 1'b1;
              wr_addr = best_idx;
            end else if (func_r == ptne_pkg::FN_DEL_NEAR) begin
              sh_nxt    = CW'(best_idx) + CW'(1);
              state_nxt = S_SHIFT;
            end
          end else begin
            res_st_nxt = ptne_pkg::ST_NONE;
          end
        end
      end
      S_IREAD: begin
        state_nxt = S_IDATA;
      end
      S_IDATA: begin
        res_found_nxt = 1'b1;
        res_idx_nxt   = ptne_pkg::MIDX_W'(act_r);
        res_x_nxt     = rd_data[ptne_pkg::POINT_W-1:XW];
        res_y_nxt     = rd_data[XW-1:0];
        if (func_r == ptne_pkg::FN_UPD_AT) begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          sh_nxt    = CW'(act_r) + CW'(1);
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sh_r < count_r) begin
          rd_addr  = sh_r[AW-1:0];
          sh_issue = 1'b1;
          sh_nxt   = sh_r + CW'(1);
        end
        if (shv_r) begin
          wr_en   = 1'b1;
          wr_addr = shw_r;
          wr_data = rd_data;
        end
        if (!sh_issue && !shv_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      iss_v_r     <= 1'b0;
      shv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      iss_v_r     <= scan_issue;
      shv_r       <= sh_issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r      <= scan_nxt;
    sh_r        <= sh_nxt;
    act_r       <= act_nxt;
    iss_idx_r   <= rd_addr;
    shw_r       <= rd_addr - AW'(1);
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    res_x_r     <= res_x_nxt;
    res_y_r     <= res_y_nxt;
    res_st_r    <= res_st_nxt;
    if (accept) begin
      func_r <= in_ch.func;
      qx_r   <= in_ch.query_x;
      qy_r   <= in_ch.query_y;
      nx_r   <= in_ch.new_x;
      ny_r   <= in_ch.new_y;
    end
    if (out_load) begin
      out_found_r <= res_found_r;
      out_idx_r   <= res_idx_r;
      out_x_r     <= res_x_r;
      out_y_r     <= res_y_r;
      out_st_r    <= res_st_r;
      out_cnt_r   <= ptne_pkg::PCNT_W'(count_r);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.match_index = out_idx_r;
  assign out_ch.match_x     = out_x_r;
  assign out_ch.match_y     = out_y_r;
  assign out_ch.status      = out_st_r;
  assign out_ch.point_count = out_cnt_r;

endmodule
`default_nettype wire

// ===== rtl/ptne_chk.sv =====
// Port-level checker for the point table, bound to the top level.
`default_nettype none
module ptne_chk (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic                                 out_found,
  input  logic [ptne_pkg::MIDX_W-1:0]          out_index,
  input  logic signed [ptne_pkg::COORD_W-1:0]  out_x,
  input  logic signed [ptne_pkg::COORD_W-1:0]  out_y,
  input  logic [ptne_pkg::STAT_W-1:0]          out_status,
  input  logic [ptne_pkg::PCNT_W-1:0]          out_count
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_found, out_index, out_x, out_y, out_status, out_count}))
    else $error("result changed while stalled");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ptne_pkg::ST_OK)
    else $error("found result with error status");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ptne_pkg::ST_NONE || out_status == ptne_pkg::ST_FULL)
      |-> out_index == '0 && out_x == '0 && out_y == '0)
    else $error("miss result carries nonzero point");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind point_table_nearest_edit ptne_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_found  (out_ch.found),
  .out_index  (out_ch.match_index),
  .out_x      (out_ch.match_x),
  .out_y      (out_ch.match_y),
  .out_status (out_ch.status),
  .out_count  (out_ch.point_count)
);
`default_nettype wire
